@@ src/bero_pkg.sv @@
// Shared beat types and register codes for the 3x3 binary erosion block.
package bero_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRUCT_MASK  = 2'd2;

  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd1024;
  localparam logic [8:0]  STRUCT_MASK_RST  = 9'h1FF;

  localparam logic [7:0] PIX_WHITE = 8'd255;
  localparam logic [7:0] PIX_BLACK = 8'd0;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_end;
  } out_item_t;

endpackage

@@ src/binary_erosion_3x3.sv @@
// Streaming 3x3 binary erosion of 8-bit raster pixels with two line stores.
// Path: an accepted input beat is held in stage A, then its result moves into the output register.
// Throughput: one beat per cycle; in_ready drops only while both stages hold a stalled beat.
// Pixel results trail the input by width+1 pixel beats; drain beats flush what is pending.
// Reset (rst_n low, synchronous): counters, window, valid flags and config registers clear to defaults;
// the line stores keep their contents and are not cleared.
module binary_erosion_3x3 import bero_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Column index, width value, pending count and modular-address widths.
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(MAX_WIDTH + 2);
  localparam int DW = WW + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [10:0] cfg_width_r;
  logic [15:0] cfg_height_r;
  logic [8:0]  cfg_mask_r;
  logic        frame_restart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= IMAGE_WIDTH_RST;
      cfg_height_r <= IMAGE_HEIGHT_RST;
      cfg_mask_r   <= STRUCT_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_width_r  <= cfg_wdata[10:0];
        REG_IMAGE_HEIGHT: cfg_height_r <= cfg_wdata[15:0];
        REG_STRUCT_MASK:  cfg_mask_r   <= cfg_wdata[8:0];
        default: ;  // index beyond the register list: drop the write
      endcase
    end
  end

  // A new width or height restarts the frame.
  assign frame_restart = cfg_we &&
                         (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // Effective frame size: width clamped to 3..MAX_WIDTH, height raised to 3.
  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;

  always_comb begin
    if (cfg_width_r < 11'd3) begin
      w_eff = WW'(3);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_r);
    end
    h_eff = (cfg_height_r < 16'd3) ? 16'd3 : cfg_height_r;
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  // Stage A holds an accepted beat while its line store reads come back; the
  // output register holds the result until the consumer takes it.
  logic a_valid_r;
  logic out_valid_r;
  logic adv;
  logic in_fire;
  logic wr_fire;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !a_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Raster counters and pending count, all updated at acceptance
  // ---------------------------------------------------------------------------
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [15:0]   in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [15:0]   out_row_r, out_row_nxt;
  logic [PW-1:0] pending_r, pending_nxt;

  logic [CW-1:0] col_c;        // write column of this pixel beat
  logic [WW-1:0] col_inc;
  logic [WW-1:0] ocol_inc;
  logic          is_drain;
  logic          emit;
  logic          drain_upper;  // drain takes the oldest pixel from the upper store
  logic [CW-1:0] rd_addr_up;
  logic [CW-1:0] rd_addr_mid;
  logic [DW-1:0] mid_diff;
  logic          frame_end_c;
  logic          inner_c;

  always_comb begin
    col_c    = (WW'(in_col_r) < w_eff) ? in_col_r : '0;
    col_inc  = WW'(col_c) + WW'(1);
    ocol_inc = WW'(out_col_r) + WW'(1);
    is_drain = (in_data.action == ACT_DRAIN);

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pending_nxt = pending_r;
    emit        = 1'b0;

    if (in_fire) begin
      if (is_drain) begin
        if (pending_r != '0) begin
          emit        = 1'b1;
          pending_nxt = pending_r - PW'(1);
        end
      end else begin
        if (col_inc >= w_eff) begin
          in_col_nxt = '0;
          in_row_nxt = (17'(in_row_r) + 17'd1 >= 17'(h_eff)) ? 16'd0 : in_row_r + 16'd1;
        end else begin
          in_col_nxt = CW'(col_inc);
        end
        if (pending_r < PW'(w_eff) + PW'(1)) begin
          pending_nxt = pending_r + PW'(1);
        end else begin
          emit = 1'b1;
        end
      end
      // Advance the output raster position for every result.
      if (emit) begin
        if (ocol_inc >= w_eff) begin
          out_col_nxt = '0;
          out_row_nxt = (17'(out_row_r) + 17'd1 >= 17'(h_eff)) ? 16'd0 : out_row_r + 16'd1;
        end else begin
          out_col_nxt = CW'(ocol_inc);
        end
      end
    end

    // Position flags of the result, taken before the output counters move.
    frame_end_c = (out_row_r == h_eff - 16'd1) && (WW'(out_col_r) == w_eff - WW'(1));
    inner_c     = (out_row_r != 16'd0) && (out_row_r < h_eff - 16'd1) &&
                  (out_col_r != '0) && (WW'(out_col_r) < w_eff - WW'(1));

    // Oldest pending pixel: width+1 beats back sits in the upper store one
    // column behind, fewer beats back sit in the middle store.
    drain_upper = (pending_r > PW'(w_eff));
    mid_diff    = DW'(col_c) + DW'(w_eff) - DW'(pending_r);

    if (is_drain && drain_upper) begin
      rd_addr_up = (col_c == '0) ? CW'(w_eff - WW'(1)) : col_c - CW'(1);
    end else begin
      rd_addr_up = col_c;
    end
    if (is_drain) begin
      rd_addr_mid = (mid_diff >= DW'(w_eff)) ? CW'(mid_diff - DW'(w_eff)) : CW'(mid_diff);
    end else begin
      rd_addr_mid = col_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || frame_restart) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pending_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pending_r <= pending_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: accepted beat plus registered line store reads
  // ---------------------------------------------------------------------------
  logic          a_pixel_r;
  logic [7:0]    a_pix_r;
  logic [CW-1:0] a_col_r;
  logic          a_emit_r;
  logic          a_upper_r;
  logic          a_inner_r;
  logic          a_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (adv) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_pixel_r <= !is_drain;
      a_pix_r   <= in_data.pixel_in;
      a_col_r   <= col_c;
      a_emit_r  <= emit;
      a_upper_r <= drain_upper;
      a_inner_r <= inner_c;
      a_fend_r  <= frame_end_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: written when a pixel beat leaves stage A, read at acceptance
  // ---------------------------------------------------------------------------
  logic [7:0] upper_mem  [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];
  logic [7:0] rd_up_r, rd_mid_r;
  logic       byp_up_r, byp_mid_r;
  logic [7:0] byp_up_d_r, byp_mid_d_r;
  logic [7:0] up_q, mid_q;

  assign wr_fire = a_valid_r && a_pixel_r && adv;
  assign up_q    = byp_up_r  ? byp_up_d_r  : rd_up_r;
  assign mid_q   = byp_mid_r ? byp_mid_d_r : rd_mid_r;

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      upper_mem[a_col_r] <= mid_q;
    end
    if (in_fire) begin
      rd_up_r <= upper_mem[rd_addr_up];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      middle_mem[a_col_r] <= a_pix_r;
    end
    if (in_fire) begin
      rd_mid_r <= middle_mem[rd_addr_mid];
    end
  end

  // Forward the write that lands on the same edge as a read of that column.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byp_up_r    <= wr_fire && (rd_addr_up == a_col_r);
      byp_mid_r   <= wr_fire && (rd_addr_mid == a_col_r);
      byp_up_d_r  <= mid_q;
      byp_mid_d_r <= a_pix_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Window shift and erosion test
  // ---------------------------------------------------------------------------
  logic [7:0] win_r   [9];
  logic [7:0] win_nxt [9];
  logic [8:0] zero_hit;
  logic [7:0] result_pix;

  always_comb begin
    // Shift each row left, load the new column: upper, middle, incoming pixel.
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = up_q;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_q;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = a_pix_r;

    for (int i = 0; i < 9; i++) begin
      zero_hit[i] = cfg_mask_r[i] && (win_nxt[i] == PIX_BLACK);
    end

    if (a_pixel_r) begin
      if (a_inner_r && (win_nxt[4] == PIX_WHITE) && (zero_hit != '0)) begin
        result_pix = PIX_BLACK;
      end else begin
        result_pix = win_nxt[4];
      end
    end else begin
      // Drain: pass the oldest pending pixel as it is.
      result_pix = a_upper_r ? up_q : mid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (wr_fire) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= a_valid_r && a_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid_r && a_emit_r) begin
      out_data_r.pixel_out <= result_pix;
      out_data_r.frame_end <= a_fend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= PW'(w_eff) + PW'(1))
    else $error("pending count above width+1");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(in_col_r) < w_eff)
    else $error("input column beyond frame width");

  a_empty_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_drain && pending_r == '0) |=> !a_emit_r)
    else $error("drain with nothing pending produced a result");

  a_emit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_emit_r && adv) |=> out_valid_r)
    else $error("result lost between stage A and output register");

  a_border_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_fend_r) |-> !a_inner_r)
    else $error("frame end marked as inner pixel");

endmodule
